// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define FK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fk_pkg.sv =====
`timescale 1ns / 1ps
package fk_pkg;

  localparam int ANG_W = 9;
  localparam int OUT_W = 18;
  localparam int Q = 30;
  localparam int IDX_W = 7;
  localparam int SIN_W = 32;
  localparam int TAB_N = 91;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] DEG_STEP = PI_Q62 / 64'd180;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
  } fold_t;

  typedef logic [Q:0] sin_tab_t [0:TAB_N-1];

  // Q30 sine of 0..90 degrees, odd Taylor series to x^15; built at elaboration
  function automatic sin_tab_t gen_sin_tab();
    sin_tab_t    tab;
    logic [63:0] xq;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int r = 0; r < TAB_N; r++) begin
      xq = (DEG_STEP * 64'(r)) >> 32;
      x2 = (xq * xq) >> Q;
      term = xq;
      sum = xq;
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> Q;
        // divide by (2k)(2k+1)
        case (k)
          1: begin
            term = term / 64'd6;
          end
          2: begin
            term = term / 64'd20;
          end
          3: begin
            term = term / 64'd42;
          end
          4: begin
            term = term / 64'd72;
          end
          5: begin
            term = term / 64'd110;
          end
          6: begin
            term = term / 64'd156;
          end
          default: begin
            term = term / 64'd210;
          end
        endcase
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      tab[r] = sum[Q:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/arm_forward_kinematics_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid / in_stall      base_angle, shoulder_angle, elbow_angle
// out       out_valid / out_stall    pos_x, pos_y, pos_z
// cfg       cfg_valid / cfg_ready    cfg_data (segment_length)
//
// Seven register stages: fold, sine table, sums, product, round, scale, round/saturate.
// One transfer per cycle while the pipeline is not held.
// The whole pipeline holds while out_valid is high and out_stall is set.
// rst (synchronous) clears valid bits and sets segment length to 85.
module arm_forward_kinematics_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [fk_pkg::ANG_W-1:0] base_angle,
  input  logic signed [fk_pkg::ANG_W-1:0] shoulder_angle,
  input  logic signed [fk_pkg::ANG_W-1:0] elbow_angle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [fk_pkg::OUT_W-1:0] pos_x,
  output logic signed [fk_pkg::OUT_W-1:0] pos_y,
  output logic signed [fk_pkg::OUT_W-1:0] pos_z,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data
);
  import fk_pkg::*;

  `include "assert_macros.svh"

  localparam int SH = Q - FRAC_BITS;
  localparam logic [43:0] HALF_SH = 44'd1 << (SH - 1);
  localparam logic [65:0] HALF_Q  = 66'd1 << (Q - 1);
  localparam logic [43:0] OUT_MAX = 44'd131071;

  logic [7:0] seg_len;
  logic       adv;
  logic [6:1] v;

  fold_t                   fold [0:5];
  logic signed [SIN_W-1:0] sv   [0:5];
  logic signed [ANG_W-1:0] ang  [0:5];

  logic signed [32:0] csum, ssum3, ssum4, ssum5;
  logic signed [31:0] cb3, sb3;
  logic signed [65:0] prod_x, prod_y;
  logic signed [33:0] px, py;
  logic signed [43:0] lx, ly, lz;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= 8'd85;
    end else if (cfg_valid && cfg_ready) begin
      seg_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[5:1], in_valid};
      out_valid <= v[6];
    end
  end

  // Lookups: 0 sin b, 1 cos b, 2 sin a1, 3 cos a1, 4 sin a2, 5 cos a2
  assign ang[0] = base_angle;
  assign ang[1] = base_angle;
  assign ang[2] = shoulder_angle;
  assign ang[3] = shoulder_angle;
  assign ang[4] = elbow_angle;
  assign ang[5] = elbow_angle;

  for (genvar g = 0; g < 6; g++) begin : g_trig
    fk_fold u_fold (
      .clk(clk), .en(adv), .cos_sel(g % 2 == 1), .angle(ang[g]), .fold(fold[g])
    );
    fk_sin_lut u_lut (
      .clk(clk), .en(adv), .fold(fold[g]), .value(sv[g])
    );
  end

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [43:0] val);
    logic        neg;
    logic [43:0] mag;
    logic [43:0] r;
    neg = val[43];
    mag = neg ? 44'(-val) : 44'(val);
    r = (mag + HALF_SH) >> SH;
    if (!neg) begin
      round_sat = (r > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(r);
    end else begin
      round_sat = (r > OUT_MAX + 44'd1) ? OUT_W'(-(OUT_MAX + 44'd1)) : OUT_W'(-r);
    end
  endfunction

  function automatic logic signed [33:0] round_q(input logic signed [65:0] val);
    logic        neg;
    logic [65:0] mag;
    logic [65:0] r;
    neg = val[65];
    mag = neg ? 66'(-val) : 66'(val);
    r = (mag + HALF_Q) >> Q;
    round_q = neg ? -$signed(r[33:0]) : $signed(r[33:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      csum  <= 33'(sv[3]) + 33'(sv[5]);
      ssum3 <= 33'(sv[2]) + 33'(sv[4]);
      cb3   <= sv[1];
      sb3   <= sv[0];

      prod_x <= 66'(csum) * 66'(cb3);
      prod_y <= 66'(csum) * 66'(sb3);
      ssum4  <= ssum3;

      px    <= round_q(prod_x);
      py    <= round_q(prod_y);
      ssum5 <= ssum4;

      lx <= 44'(px) * $signed({36'd0, seg_len});
      ly <= 44'(py) * $signed({36'd0, seg_len});
      lz <= 44'(ssum5) * $signed({36'd0, seg_len});

      pos_x <= round_sat(lx);
      pos_y <= round_sat(ly);
      pos_z <= round_sat(lz);
    end
  end

  `FK_ASSERT_NEXT(a_entry, in_valid && !in_stall, v[1], "accepted item not in stage one")
  `FK_ASSERT_NEXT(a_bubble, adv && !in_valid, !v[1], "bubble turned into an item")
  `FK_ASSERT_NOW(a_zero_len, out_valid && seg_len == 8'd0,
                 pos_x == '0 && pos_y == '0 && pos_z == '0, "zero length gives nonzero tip")

endmodule

// ===== rtl/fk_fold.sv =====
`timescale 1ns / 1ps
// Wraps an angle (plus 90 for cosine) to 0..359 and folds it into the first quadrant.
module fk_fold (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            cos_sel,
  input  logic signed [fk_pkg::ANG_W-1:0] angle,
  output fk_pkg::fold_t                   fold
);
  import fk_pkg::*;

  localparam logic signed [10:0] DEG90  = 11'sd90;
  localparam logic signed [10:0] DEG360 = 11'sd360;

  logic signed [10:0] t;
  logic signed [10:0] m;
  fold_t              fold_next;

  always_comb begin
    t = {{2{angle[ANG_W-1]}}, angle} + (cos_sel ? DEG90 : 11'sd0);
    if (t < 0) begin
      m = t + DEG360;
    end else if (t >= DEG360) begin
      m = t - DEG360;
    end else begin
      m = t;
    end
    if (m <= 11'sd90) begin
      fold_next.idx = m[IDX_W-1:0];
      fold_next.neg = 1'b0;
    end else if (m <= 11'sd180) begin
      fold_next.idx = 7'(11'sd180 - m);
      fold_next.neg = 1'b0;
    end else if (m <= 11'sd270) begin
      fold_next.idx = 7'(m - 11'sd180);
      fold_next.neg = 1'b1;
    end else begin
      fold_next.idx = 7'(DEG360 - m);
      fold_next.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold <= fold_next;
    end
  end

endmodule

// ===== rtl/fk_sin_lut.sv =====
`timescale 1ns / 1ps
// Quarter-wave sine table with sign, registered output.
module fk_sin_lut (
  input  logic                             clk,
  input  logic                             en,
  input  fk_pkg::fold_t                    fold,
  output logic signed [fk_pkg::SIN_W-1:0]  value
);
  import fk_pkg::*;

  localparam sin_tab_t SIN_TAB = gen_sin_tab();

  logic [Q:0]              mag;
  logic signed [SIN_W-1:0] value_next;

  always_comb begin
    mag = (fold.idx < 7'(TAB_N)) ? SIN_TAB[fold.idx] : '0;
    value_next = fold.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule
